### rtl/core/keypad_code_lock_defines.svh
// Assertion macros shared by the keypad code lock RTL.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

`ifndef SYNTHESIS
`define KCL_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define KCL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define KCL_ASSERT(label, clk, rst, cond, msg)
`define KCL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/kcl_pkg.sv
// Types and constants of the keypad code lock.
package kcl_pkg;

  typedef enum logic [2:0] {
    OUT_IGNORED = 3'd0,
    OUT_STORED  = 3'd1,
    OUT_CLEARED = 3'd2,
    OUT_CHANGE  = 3'd3,
    OUT_CORRECT = 3'd4,
    OUT_WRONG   = 3'd5,
    OUT_LOCKED  = 3'd6,
    OUT_CHANGED = 3'd7
  } outcome_t;

  localparam logic [7:0] KEY_NONE   = 8'h00;
  localparam logic [7:0] KEY_CLEAR  = 8'h2A;
  localparam logic [7:0] KEY_CHANGE = 8'h23;
  localparam logic [7:0] CHAR_ONE   = 8'h31;

  localparam logic [3:0] FAIL_SAT     = 4'hF;
  localparam logic [3:0] MAX_FAIL_RST = 4'd3;

  typedef struct packed {
    outcome_t   outcome;
    logic       is_unlocked;
    logic       is_locked_out;
    logic       in_change_mode;
    logic [2:0] chars_entered;
    logic [3:0] failures;
  } result_t;

endpackage

### rtl/core/kcl_if.sv
// Handshake interfaces for key items and result items.
interface kcl_key_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] key_code;

  modport source (output valid, output action, output key_code, input ready);
  modport sink (input valid, input action, input key_code, output ready);
endinterface

interface kcl_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic       is_unlocked;
  logic       is_locked_out;
  logic       in_change_mode;
  logic [2:0] chars_entered;
  logic [3:0] failures;

  modport source (
    output valid, output outcome, output is_unlocked, output is_locked_out,
    output in_change_mode, output chars_entered, output failures, input ready
  );
  modport sink (
    input valid, input outcome, input is_unlocked, input is_locked_out,
    input in_change_mode, input chars_entered, input failures, output ready
  );
endinterface

### rtl/core/kcl_core.sv
// Lock state registers and the combinational next-state update for one key item.
`include "keypad_code_lock_defines.svh"

module kcl_core #(
  parameter int CODE_LEN = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            action,
  input  logic [7:0]      key_code,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  output kcl_pkg::result_t result
);
  import kcl_pkg::*;

  localparam int CW = $clog2(CODE_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(CODE_LEN);

  logic [CODE_LEN-1:0][7:0] stored_code;
  logic [CODE_LEN-1:0][7:0] stored_code_next;
  logic [CODE_LEN-1:0][7:0] entry_chars;
  logic [CODE_LEN-1:0][7:0] full_entry;
  logic [CW-1:0]            entry_count;
  logic [CW-1:0]            entry_count_next;
  logic [CW-1:0]            count_inc;
  logic [3:0]               fail_counter;
  logic [3:0]               fail_counter_next;
  logic [3:0]               fail_inc;
  logic                     unlock_flag;
  logic                     unlock_flag_next;
  logic                     lockout_flag;
  logic                     lockout_flag_next;
  logic                     change_flag;
  logic                     change_flag_next;
  logic [3:0]               max_failures;
  logic                     entry_we;
  logic                     code_we;
  outcome_t                 outcome;

  always_comb begin
    full_entry = entry_chars;
    full_entry[CODE_LEN-1] = key_code;
  end

  assign count_inc = entry_count + CW'(1);
  assign fail_inc  = (fail_counter == FAIL_SAT) ? fail_counter : fail_counter + 4'd1;

  always_comb begin
    entry_count_next  = entry_count;
    fail_counter_next = fail_counter;
    unlock_flag_next  = unlock_flag;
    lockout_flag_next = lockout_flag;
    change_flag_next  = change_flag;
    stored_code_next  = stored_code;
    entry_we          = 1'b0;
    code_we           = 1'b0;
    outcome           = OUT_IGNORED;
    priority if (action || (key_code == KEY_CLEAR)) begin
      entry_count_next  = '0;
      fail_counter_next = '0;
      unlock_flag_next  = 1'b0;
      lockout_flag_next = 1'b0;
      change_flag_next  = 1'b0;
      outcome           = OUT_CLEARED;
    end else if ((key_code == KEY_NONE) || lockout_flag) begin
      outcome = OUT_IGNORED;
    end else if (key_code == KEY_CHANGE) begin
      change_flag_next = 1'b1;
      entry_count_next = '0;
      outcome          = OUT_CHANGE;
    end else if (entry_count >= FULL) begin
      outcome = OUT_IGNORED;
    end else if (count_inc < FULL) begin
      entry_we         = 1'b1;
      entry_count_next = count_inc;
      outcome          = OUT_STORED;
    end else if (change_flag) begin
      entry_we          = 1'b1;
      code_we           = 1'b1;
      stored_code_next  = full_entry;
      entry_count_next  = '0;
      fail_counter_next = '0;
      unlock_flag_next  = 1'b0;
      lockout_flag_next = 1'b0;
      change_flag_next  = 1'b0;
      outcome           = OUT_CHANGED;
    end else if (full_entry == stored_code) begin
      entry_we          = 1'b1;
      entry_count_next  = count_inc;
      unlock_flag_next  = 1'b1;
      fail_counter_next = '0;
      outcome           = OUT_CORRECT;
    end else begin
      entry_we          = 1'b1;
      entry_count_next  = '0;
      unlock_flag_next  = 1'b0;
      fail_counter_next = fail_inc;
      if (fail_inc >= max_failures) begin
        lockout_flag_next = 1'b1;
        outcome           = OUT_LOCKED;
      end else begin
        outcome = OUT_WRONG;
      end
    end
  end

  always_comb begin
    result.outcome        = outcome;
    result.is_unlocked    = unlock_flag_next;
    result.is_locked_out  = lockout_flag_next;
    result.in_change_mode = change_flag_next;
    result.chars_entered  = 3'(entry_count_next);
    result.failures       = fail_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      fail_counter <= '0;
      unlock_flag  <= 1'b0;
      lockout_flag <= 1'b0;
      change_flag  <= 1'b0;
    end else if (accept) begin
      entry_count  <= entry_count_next;
      fail_counter <= fail_counter_next;
      unlock_flag  <= unlock_flag_next;
      lockout_flag <= lockout_flag_next;
      change_flag  <= change_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_failures <= MAX_FAIL_RST;
    end else if (cfg_we) begin
      max_failures <= cfg_data;
    end
  end

  for (genvar i = 0; i < CODE_LEN; i++) begin : g_chars
    localparam logic [7:0] RST_CHAR = 8'(CHAR_ONE + (i % 10));

    always_ff @(posedge clk) begin
      if (rst) begin
        stored_code[i] <= RST_CHAR;
      end else if (accept && code_we) begin
        stored_code[i] <= stored_code_next[i];
      end
    end

    always_ff @(posedge clk) begin
      if (accept && entry_we && (entry_count == CW'(i))) begin
        entry_chars[i] <= key_code;
      end
    end
  end

  `KCL_ASSERT(a_count_range, clk, rst, entry_count <= FULL, "entry count beyond code length")
  `KCL_ASSERT_IMPLY(a_lockout_fail, clk, rst, lockout_flag, fail_counter != 4'd0, "lockout without failures")
  `KCL_ASSERT_IMPLY(a_unlock_excl, clk, rst, unlock_flag, !lockout_flag, "unlocked while locked out")

endmodule

### rtl/core/kcl_skid.sv
// Two-entry result buffer that decouples the lock update from the result channel.
`include "keypad_code_lock_defines.svh"

module kcl_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  kcl_pkg::result_t in_data,
  output logic             up_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output kcl_pkg::result_t out_data
);
  import kcl_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    stalled;
  logic    accept;

  assign up_ready = !skid_valid;
  assign accept   = in_valid && up_ready;
  assign stalled  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (stalled) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (stalled) begin
      if (accept) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (accept) begin
      out_data <= in_data;
    end
  end

  `KCL_ASSERT_IMPLY(a_skid_order, clk, rst, skid_valid, out_valid, "buffered item with empty output")
  `KCL_ASSERT_IMPLY(a_no_drop, clk, rst, stalled && skid_valid, !accept, "item accepted with buffer full")

endmodule

### rtl/core/keypad_code_lock.sv
// Top level of the keypad code lock.
// A result item is registered when its key item is accepted. One key item per
// cycle while no item waits in the skid entry; the two-entry buffer keeps input
// ready for one more item while a result waits to be taken.
// Reset: synchronous; clears entry, flags and failures, loads code "1234" and a
// failure limit of 3. No further start-up cycles are needed.
module keypad_code_lock #(
  parameter int CODE_LEN = 4
) (
  input  logic       clk,
  input  logic       rst,
  kcl_key_if.sink    keys,
  kcl_result_if.source result,
  input  logic       max_failures_we,
  input  logic [3:0] max_failures_wdata
);
  import kcl_pkg::*;

  logic    accept;
  logic    up_ready;
  result_t core_result;
  result_t buf_result;

  assign keys.ready = up_ready;
  assign accept     = keys.valid && up_ready;

  kcl_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (keys.action),
    .key_code (keys.key_code),
    .cfg_we   (max_failures_we),
    .cfg_data (max_failures_wdata),
    .result   (core_result)
  );

  kcl_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (core_result),
    .up_ready  (up_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (buf_result)
  );

  assign result.outcome        = buf_result.outcome;
  assign result.is_unlocked    = buf_result.is_unlocked;
  assign result.is_locked_out  = buf_result.is_locked_out;
  assign result.in_change_mode = buf_result.in_change_mode;
  assign result.chars_entered  = buf_result.chars_entered;
  assign result.failures       = buf_result.failures;

endmodule
